// ===== sv/ffa_pkg.sv =====
// Package for the first-fit block allocator.
// Holds block kind codes, status and command codes, and the structs passed between modules.
// No dependencies.
package ffa_pkg;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_FREE = 2'd1,
    KIND_USED = 2'd2
  } kind_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SIZE    = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;
  localparam logic [1:0] ST_BADFREE = 2'd3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    logic clr;
    logic add;
    logic used;
  } ffa_stat_ctl_t;

  typedef struct packed {
    logic        load;
    logic [1:0]  status;
    logic [11:0] poff;
  } ffa_res_t;

endpackage

// ===== sv/ffa_mem.sv =====
// Block table memory: one entry per 8-byte granule holding kind and payload length.
// Single port, registered synchronous read. Uses ffa_pkg.
module ffa_mem import ffa_pkg::*; #(
  parameter int DEPTH = 512,
  parameter int DW    = 15,
  localparam int GW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [GW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sv/ffa_stats.sv =====
// Statistics accumulator: occupied bytes, used and free counts, smallest and largest free payload.
// Cleared and fed one block at a time by the sequencer. Uses ffa_pkg.
module ffa_stats import ffa_pkg::*; #(
  parameter int ARENA_BYTES = 4096,
  parameter int BLOCK_HDR   = 24,
  parameter int GRANULES    = 512,
  localparam int OW         = $clog2(ARENA_BYTES + 1),
  localparam int CW         = $clog2(GRANULES + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  ffa_stat_ctl_t ctl,
  input  logic [OW-1:0] len,
  output logic [OW-1:0] occ,
  output logic [CW-1:0] used_cnt,
  output logic [CW-1:0] free_cnt,
  output logic [OW-1:0] min_free,
  output logic [OW-1:0] max_free
);

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      occ      <= '0;
      used_cnt <= '0;
      free_cnt <= '0;
      min_free <= '0;
      max_free <= '0;
    end else if (ctl.add) begin
      if (ctl.used) begin
        occ      <= occ + len + OW'(BLOCK_HDR);
        used_cnt <= used_cnt + CW'(1);
      end else begin
        if (free_cnt == '0 || len < min_free) begin
          min_free <= len;
        end
        if (free_cnt == '0 || len > max_free) begin
          max_free <= len;
        end
        free_cnt <= free_cnt + CW'(1);
      end
    end
  end

endmodule

// ===== sv/ffa_seq.sv =====
// Sequencer: clears the table after reset, walks it for allocate and free, and rescans it
// to rebuild the statistics. Drives the table memory and the accumulator. Uses ffa_pkg.
module ffa_seq import ffa_pkg::*; #(
  parameter int ARENA_BYTES = 4096,
  parameter int BLOCK_HDR   = 24,
  parameter int ARENA_HDR   = 40,
  parameter int GRANULES    = 512,
  localparam int GW         = $clog2(GRANULES),
  localparam int OW         = $clog2(ARENA_BYTES + 1),
  localparam int LW         = OW,
  localparam int CW         = $clog2(GRANULES + 1),
  localparam int DW         = LW + 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          cmd,
  input  logic [11:0]   req_size,
  input  logic [11:0]   req_offset,
  input  logic          out_free,
  output ffa_res_t      res,
  output logic          mem_we,
  output logic [GW-1:0] mem_addr,
  output logic [DW-1:0] mem_wdata,
  input  logic [DW-1:0] mem_rdata,
  output ffa_stat_ctl_t st_ctl,
  output logic [LW-1:0] st_len,
  input  logic [OW-1:0] occ,
  input  logic [CW-1:0] fcnt
);

  localparam int AW0 = $clog2(ARENA_BYTES + BLOCK_HDR + 1);
  localparam int AW1 = (AW0 > 13) ? AW0 : 13;
  localparam int AW  = (AW1 > GW + 4) ? AW1 : GW + 4;
  localparam int WW  = OW + CW + 8;
  localparam int I0  = ARENA_HDR / 8;
  localparam bit INIT_OK = (I0 < GRANULES) && (ARENA_HDR + BLOCK_HDR <= ARENA_BYTES);
  localparam int INIT_LEN = INIT_OK ? (ARENA_BYTES - ARENA_HDR - BLOCK_HDR) : 0;

  typedef enum logic [11:0] {
    S_CLEAR  = 12'b000000000001,
    S_IDLE   = 12'b000000000010,
    S_WALK   = 12'b000000000100,
    S_LOOK   = 12'b000000001000,
    S_NWALK  = 12'b000000010000,
    S_NLOOK  = 12'b000000100000,
    S_MERGE  = 12'b000001000000,
    S_WRA    = 12'b000010000000,
    S_RSTART = 12'b000100000000,
    S_SUM    = 12'b001000000000,
    S_SUMLK  = 12'b010000000000,
    S_DONE   = 12'b100000000000
  } state_t;

  state_t        state, state_next;
  logic          busy, busy_next;
  logic [AW-1:0] s, s_next;
  logic          cmd_r, cmd_r_next;
  logic [11:0]   size_r, size_r_next;
  logic [11:0]   off_r, off_r_next;
  logic [1:0]    status, status_next;
  logic [11:0]   poff, poff_next;
  logic          have_prev, have_prev_next;
  logic          prev_free, prev_free_next;
  logic [GW-1:0] prev_idx, prev_idx_next;
  logic [LW-1:0] prev_len, prev_len_next;
  logic [GW-1:0] cur_idx, cur_idx_next;
  logic [LW-1:0] cur_len, cur_len_next;
  logic [GW-1:0] wa_addr, wa_addr_next;
  logic [DW-1:0] wa_data, wa_data_next;
  logic [GW-1:0] clr_cnt, clr_cnt_next;

  kind_t         rd_kind;
  logic [LW-1:0] rd_len;
  logic [GW-1:0] s_idx;
  logic          s_in;
  logic [AW-1:0] hdr_end, nxt, ns, rest, size_x, off_x;
  logic          fit;
  logic [1:0]    fail_code;
  logic [WW-1:0] need;

  always_comb begin
    rd_kind   = kind_t'(mem_rdata[DW-1:LW]);
    rd_len    = mem_rdata[LW-1:0];
    s_idx     = GW'(s >> 3);
    hdr_end   = s + AW'(BLOCK_HDR);
    s_in      = (hdr_end <= AW'(ARENA_BYTES)) && ((s >> 3) < AW'(GRANULES));
    nxt       = hdr_end + AW'(rd_len);
    size_x    = AW'(size_r);
    off_x     = AW'(off_r);
    ns        = hdr_end + size_x;
    rest      = AW'(rd_len) - size_x;
    fit       = (rd_kind == KIND_FREE) && (AW'(rd_len) >= size_x);
    fail_code = (cmd_r == CMD_ALLOC) ? ST_NOSPACE : ST_BADFREE;
    need      = WW'(req_size) + WW'(BLOCK_HDR) + WW'(occ) + WW'(fcnt) * WW'(BLOCK_HDR);
  end

  always_comb begin
    state_next     = state;
    busy_next      = busy;
    s_next         = s;
    cmd_r_next     = cmd_r;
    size_r_next    = size_r;
    off_r_next     = off_r;
    status_next    = status;
    poff_next      = poff;
    have_prev_next = have_prev;
    prev_free_next = prev_free;
    prev_idx_next  = prev_idx;
    prev_len_next  = prev_len;
    cur_idx_next   = cur_idx;
    cur_len_next   = cur_len;
    wa_addr_next   = wa_addr;
    wa_data_next   = wa_data;
    clr_cnt_next   = clr_cnt;
    mem_we         = 1'b0;
    mem_addr       = s_idx;
    mem_wdata      = '0;
    st_ctl         = '0;
    st_len         = rd_len;
    in_ready       = (state == S_IDLE);
    res.load       = 1'b0;
    res.status     = status;
    res.poff       = poff;

    unique case (state)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_cnt;
        if (INIT_OK && clr_cnt == GW'(I0)) begin
          mem_wdata = {KIND_FREE, LW'(INIT_LEN)};
        end
        clr_cnt_next = clr_cnt + GW'(1);
        if (clr_cnt == GW'(GRANULES - 1)) begin
          state_next = S_RSTART;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          busy_next      = 1'b1;
          cmd_r_next     = cmd;
          size_r_next    = req_size;
          off_r_next     = req_offset;
          status_next    = ST_OK;
          poff_next      = '0;
          have_prev_next = 1'b0;
          s_next         = AW'(ARENA_HDR);
          state_next     = S_WALK;
          if (cmd == CMD_ALLOC) begin
            if (req_size[2:0] != 3'd0) begin
              status_next = ST_SIZE;
              state_next  = S_DONE;
            end else if (need > WW'(ARENA_BYTES - ARENA_HDR)) begin
              status_next = ST_NOSPACE;
              state_next  = S_DONE;
            end
          end
        end
      end
      S_WALK: begin
        if (s_in) begin
          state_next = S_LOOK;
        end else begin
          status_next = fail_code;
          state_next  = S_DONE;
        end
      end
      S_LOOK: begin
        if (rd_kind == KIND_NONE) begin
          status_next = fail_code;
          state_next  = S_DONE;
        end else if (cmd_r == CMD_ALLOC) begin
          if (fit) begin
            poff_next = 12'(hdr_end);
            if (rest >= AW'(BLOCK_HDR) && (ns >> 3) < AW'(GRANULES)) begin
              mem_we       = 1'b1;
              mem_addr     = GW'(ns >> 3);
              mem_wdata    = {KIND_FREE, LW'(rest - AW'(BLOCK_HDR))};
              wa_addr_next = s_idx;
              wa_data_next = {KIND_USED, LW'(size_r)};
              state_next   = S_WRA;
            end else begin
              mem_we     = 1'b1;
              mem_wdata  = {KIND_USED, rd_len};
              state_next = S_RSTART;
            end
          end else begin
            s_next     = nxt;
            state_next = S_WALK;
          end
        end else begin
          if (hdr_end == off_x) begin
            if (rd_kind != KIND_USED) begin
              status_next = ST_BADFREE;
              state_next  = S_DONE;
            end else begin
              cur_idx_next = s_idx;
              cur_len_next = rd_len;
              s_next       = nxt;
              state_next   = S_NWALK;
            end
          end else if (hdr_end > off_x) begin
            status_next = ST_BADFREE;
            state_next  = S_DONE;
          end else begin
            prev_idx_next  = s_idx;
            prev_len_next  = rd_len;
            prev_free_next = (rd_kind == KIND_FREE);
            have_prev_next = 1'b1;
            s_next         = nxt;
            state_next     = S_WALK;
          end
        end
      end
      S_NWALK: begin
        state_next = s_in ? S_NLOOK : S_MERGE;
      end
      S_NLOOK: begin
        if (rd_kind == KIND_FREE) begin
          cur_len_next = LW'(AW'(cur_len) + AW'(BLOCK_HDR) + AW'(rd_len));
          mem_we       = 1'b1;
        end
        state_next = S_MERGE;
      end
      S_MERGE: begin
        mem_we = 1'b1;
        if (have_prev && prev_free) begin
          mem_addr     = prev_idx;
          mem_wdata    = {KIND_FREE, LW'(AW'(prev_len) + AW'(BLOCK_HDR) + AW'(cur_len))};
          wa_addr_next = cur_idx;
          wa_data_next = '0;
          state_next   = S_WRA;
        end else begin
          mem_addr   = cur_idx;
          mem_wdata  = {KIND_FREE, cur_len};
          state_next = S_RSTART;
        end
      end
      S_WRA: begin
        mem_we     = 1'b1;
        mem_addr   = wa_addr;
        mem_wdata  = wa_data;
        state_next = S_RSTART;
      end
      S_RSTART: begin
        st_ctl.clr = 1'b1;
        s_next     = AW'(ARENA_HDR);
        state_next = S_SUM;
      end
      S_SUM: begin
        state_next = s_in ? S_SUMLK : S_DONE;
      end
      S_SUMLK: begin
        if (rd_kind == KIND_NONE) begin
          state_next = S_DONE;
        end else begin
          st_ctl.add  = 1'b1;
          st_ctl.used = (rd_kind == KIND_USED);
          s_next      = nxt;
          state_next  = S_SUM;
        end
      end
      S_DONE: begin
        if (!busy) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          res.load   = 1'b1;
          busy_next  = 1'b0;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      busy    <= 1'b0;
      clr_cnt <= '0;
    end else begin
      state   <= state_next;
      busy    <= busy_next;
      clr_cnt <= clr_cnt_next;
    end
    s         <= s_next;
    cmd_r     <= cmd_r_next;
    size_r    <= size_r_next;
    off_r     <= off_r_next;
    status    <= status_next;
    poff      <= poff_next;
    have_prev <= have_prev_next;
    prev_free <= prev_free_next;
    prev_idx  <= prev_idx_next;
    prev_len  <= prev_len_next;
    cur_idx   <= cur_idx_next;
    cur_len   <= cur_len_next;
    wa_addr   <= wa_addr_next;
    wa_data   <= wa_data_next;
  end

endmodule

// ===== sv/first_fit_block_allocator.sv =====
// First-fit allocator with coalescing: top level with stream ports and result register.
// Instantiates ffa_mem, ffa_stats and ffa_seq. Uses ffa_pkg.
//
// Requests arrive on the s_ channel, one word each: s_tuser selects allocate (0) or
// free (1), s_tdata carries the requested size and the payload offset to free.
// Each request gives exactly one result word on the m_ channel with a status,
// the payload offset of a new block and statistics rebuilt from the block table.
// A request is taken only while no other is in progress. A rejected size goes straight
// to the result without a walk. Otherwise the sequencer walks the block table, one
// memory read per block visited, writes back at most three entries and then rescans
// every block to rebuild the statistics.
// After reset a clearing pass writes every entry of the table, followed by one rescan
// that gives no result word; s_tready stays low until it ends.
// The result waits in an output register while m_tready is low; the next request
// may be accepted meanwhile, and its result is held back until the register frees.
module first_fit_block_allocator import ffa_pkg::*; #(
  parameter int ARENA_BYTES = 4096,
  parameter int BLOCK_HDR   = 24,
  parameter int ARENA_HDR   = 40,
  parameter int GRANULES    = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // req_size, req_offset
  input  logic [0:0]  s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata    // status, payload_offset, bytes_occupied, used_blocks,
                                 // free_blocks, smallest_free, largest_free, zero pad
);

  localparam int GW = $clog2(GRANULES);
  localparam int OW = $clog2(ARENA_BYTES + 1);
  localparam int LW = OW;
  localparam int CW = $clog2(GRANULES + 1);
  localparam int DW = LW + 2;

  logic          mem_we;
  logic [GW-1:0] mem_addr;
  logic [DW-1:0] mem_wdata, mem_rdata;
  ffa_stat_ctl_t st_ctl;
  logic [LW-1:0] st_len;
  logic [OW-1:0] occ, min_free, max_free;
  logic [CW-1:0] used_cnt, free_cnt;
  ffa_res_t      res;
  logic          out_free;

  assign out_free = !m_tvalid || m_tready;

  ffa_mem #(.DEPTH(GRANULES), .DW(DW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  ffa_stats #(.ARENA_BYTES(ARENA_BYTES), .BLOCK_HDR(BLOCK_HDR), .GRANULES(GRANULES)) u_stats (
    .clk      (clk),
    .rst      (rst),
    .ctl      (st_ctl),
    .len      (st_len),
    .occ      (occ),
    .used_cnt (used_cnt),
    .free_cnt (free_cnt),
    .min_free (min_free),
    .max_free (max_free)
  );

  ffa_seq #(
    .ARENA_BYTES(ARENA_BYTES), .BLOCK_HDR(BLOCK_HDR),
    .ARENA_HDR(ARENA_HDR), .GRANULES(GRANULES)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .cmd        (s_tuser[0]),
    .req_size   (s_tdata[11:0]),
    .req_offset (s_tdata[23:12]),
    .out_free   (out_free),
    .res        (res),
    .mem_we     (mem_we),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata),
    .mem_rdata  (mem_rdata),
    .st_ctl     (st_ctl),
    .st_len     (st_len),
    .occ        (occ),
    .fcnt       (free_cnt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (res.load) begin
      m_tdata <= {4'b0, 12'(max_free), 12'(min_free), 9'(free_cnt), 9'(used_cnt),
                  12'(occ), res.poff, res.status};
    end
  end

`ifndef SYNTH
  a_fail_no_offset: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] != ST_OK |-> m_tdata[13:2] == 12'd0)
    else $error("failed request reports a payload offset");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[55:44] <= m_tdata[67:56])
    else $error("smallest free chunk exceeds largest");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while one is in progress");
`endif

endmodule
